@@ rtl/core/floppy_controller_register_model_assert.svh @@
// Assertion macros shared by the floppy controller register model RTL.
// FDC_ASSERT checks a property while reset is released.
// FDC_ASSERT_ALWAYS checks a property at every clock edge, reset included.
`ifndef FLOPPY_CONTROLLER_REGISTER_MODEL_ASSERT_SVH
`define FLOPPY_CONTROLLER_REGISTER_MODEL_ASSERT_SVH

`ifndef SYNTHESIS

`define FDC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define FDC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define FDC_ASSERT(lbl, clk, rst_n, prop, msg)

`define FDC_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

@@ rtl/core/fdc_pkg.sv @@
`timescale 1ns / 1ps

package fdc_pkg;

  // Geometry defaults.
  localparam int LONG_SECTOR_BYTES_DEF  = 1024;
  localparam int SHORT_SECTOR_BYTES_DEF = 512;
  localparam int TRACK_BYTES_DEF        = 5632;

  // Fixed field widths.
  localparam int BYTE_W   = 8;
  localparam int IDX_W    = 11;
  localparam int WAIT_W   = 4;
  localparam int STAT_W   = 3;
  localparam int ADDR_W   = 21;
  localparam int APB_AW   = 3;
  localparam int APB_DW   = 32;

  // Item kinds.
  localparam logic [1:0] KIND_READ  = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_TICK  = 2'd2;

  // Register selects.
  localparam logic [1:0] SEL_STATUS = 2'd0;
  localparam logic [1:0] SEL_TRACK  = 2'd1;
  localparam logic [1:0] SEL_SECTOR = 2'd2;
  localparam logic [1:0] SEL_DATA   = 2'd3;

  // Command opcodes (upper nibble of the command byte).
  localparam logic [3:0] OP_RESTORE     = 4'h0;
  localparam logic [3:0] OP_SEEK        = 4'h1;
  localparam logic [3:0] OP_STEP        = 4'h2;
  localparam logic [3:0] OP_STEP_U      = 4'h3;
  localparam logic [3:0] OP_STEP_IN     = 4'h4;
  localparam logic [3:0] OP_STEP_IN_U   = 4'h5;
  localparam logic [3:0] OP_STEP_OUT    = 4'h6;
  localparam logic [3:0] OP_STEP_OUT_U  = 4'h7;
  localparam logic [3:0] OP_READ_SECTOR = 4'h8;
  localparam logic [3:0] OP_FORCE_INT   = 4'hd;

  // Status bit positions.
  localparam int ST_BUSY = 0;
  localparam int ST_DRQ  = 1;
  localparam int ST_TR00 = 2;

  // Sector register value that selects the short sector length.
  localparam logic [BYTE_W-1:0] SHORT_SECTOR_ID = 8'd5;

  // Configuration register indexes and reset values.
  localparam logic CFG_COMMAND_DELAY = 1'b0;
  localparam logic CFG_STEP_DELAY    = 1'b1;
  localparam logic [WAIT_W-1:0] COMMAND_DELAY_RST = 4'd2;
  localparam logic [WAIT_W-1:0] STEP_DELAY_RST    = 4'd5;

  typedef struct packed {
    logic [WAIT_W-1:0] command_delay;
    logic [WAIT_W-1:0] step_delay;
  } fdc_cfg_t;

  // Step result of the engine; busy, track, sector and byte index are next-state values.
  typedef struct packed {
    logic [BYTE_W-1:0] read_data;
    logic              data_request;
    logic              command_done;
    logic              busy;
    logic [BYTE_W-1:0] track;
    logic [BYTE_W-1:0] sector;
    logic [IDX_W-1:0]  byte_index;
  } fdc_step_t;

endpackage

@@ rtl/core/fdc_stream_if.sv @@
`timescale 1ns / 1ps

interface fdc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [1:0] reg_select;
  logic [7:0] write_data;
  logic [7:0] disk_byte;

  modport source (output valid, kind, reg_select, write_data, disk_byte, input ready);
  modport sink (input valid, kind, reg_select, write_data, disk_byte, output ready);
endinterface

interface fdc_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  read_data;
  logic        data_request;
  logic        command_done;
  logic        busy_res;
  logic [20:0] disk_address;

  modport source (output valid, read_data, data_request, command_done, busy_res,
                  disk_address, input ready);
  modport sink (input valid, read_data, data_request, command_done, busy_res,
                disk_address, output ready);
endinterface

@@ rtl/core/floppy_controller_register_model.sv @@
// Channel    Dir  Handshake     Payload
// item_i     in   valid/ready   kind, reg_select, write_data, disk_byte
// result_o   out  valid/ready   read_data, data_request, command_done, busy_res,
//                               disk_address
// APB        in   psel/penable  command_delay (0x0), step_delay (0x4)
//
// One item is accepted per clock while the input side is ready; its result
// appears in the output register on the next cycle. The input side stays ready
// while the output register is empty or being drained, so a stalled result
// holds off only new items, never an item already taken. Reset is asynchronous
// and active low; it clears all controller state, empties the output register
// and restores the default delays.
`timescale 1ns / 1ps

`include "floppy_controller_register_model_assert.svh"

module floppy_controller_register_model #(
  parameter int LONG_SECTOR_BYTES  = fdc_pkg::LONG_SECTOR_BYTES_DEF,
  parameter int SHORT_SECTOR_BYTES = fdc_pkg::SHORT_SECTOR_BYTES_DEF,
  parameter int TRACK_BYTES        = fdc_pkg::TRACK_BYTES_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  fdc_in_if.sink                     item_i,
  fdc_out_if.source                  result_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [fdc_pkg::APB_AW-1:0] paddr,
  input  logic [fdc_pkg::APB_DW-1:0] pwdata,
  output logic [fdc_pkg::APB_DW-1:0] prdata,
  output logic                       pready
);

  // Address scale factors, sized to the address width so that the products
  // wrap exactly as the 21-bit disk address does.
  localparam logic [fdc_pkg::ADDR_W-1:0] SectorScale = fdc_pkg::ADDR_W'(LONG_SECTOR_BYTES);
  localparam logic [fdc_pkg::ADDR_W-1:0] TrackScale  = fdc_pkg::ADDR_W'(TRACK_BYTES);

  fdc_pkg::fdc_cfg_t  cfg;
  fdc_pkg::fdc_step_t step;

  logic                        accept;
  logic                        out_valid_q, out_valid_d;
  logic [fdc_pkg::BYTE_W-1:0]  read_data_q;
  logic                        drq_q;
  logic                        done_q;
  logic                        busy_q;
  logic [fdc_pkg::ADDR_W-1:0]  addr_q, addr_d;

  // Configuration registers behind the APB port.
  fdc_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // The output register is free when it is empty or its item leaves this cycle.
  assign item_i.ready = !out_valid_q || result_o.ready;
  assign accept       = item_i.valid && item_i.ready;

  // Controller state; it advances only on an accepted item.
  fdc_engine #(
    .LONG_SECTOR_BYTES  (LONG_SECTOR_BYTES),
    .SHORT_SECTOR_BYTES (SHORT_SECTOR_BYTES)
  ) u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .kind_i       (item_i.kind),
    .reg_select_i (item_i.reg_select),
    .write_data_i (item_i.write_data),
    .disk_byte_i  (item_i.disk_byte),
    .cfg_i        (cfg),
    .step_o       (step)
  );

  // Disk address of the next byte wanted, from the updated sector, track and
  // byte index. The products are by elaboration constants.
  assign addr_d = fdc_pkg::ADDR_W'(step.sector) * SectorScale
                + fdc_pkg::ADDR_W'(step.track) * TrackScale
                + fdc_pkg::ADDR_W'(step.byte_index);

  always_comb begin
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (result_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload; no reset needed since valid guards it.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      read_data_q <= step.read_data;
      drq_q       <= step.data_request;
      done_q      <= step.command_done;
      busy_q      <= step.busy;
      addr_q      <= addr_d;
    end
  end

  assign result_o.valid        = out_valid_q;
  assign result_o.read_data    = read_data_q;
  assign result_o.data_request = drq_q;
  assign result_o.command_done = done_q;
  assign result_o.busy_res     = busy_q;
  assign result_o.disk_address = addr_q;

  // A byte is delivered only while a sector read stays busy.
  `FDC_ASSERT(a_drq_busy, clk_i, rst_ni, (out_valid_q && drq_q) |-> busy_q, "drq without busy")

  // Every completed command leaves busy clear.
  `FDC_ASSERT(a_done_idle, clk_i, rst_ni, (out_valid_q && done_q) |-> !busy_q, "done while busy")

  // A step never both delivers a byte and completes the command.
  `FDC_ASSERT(a_drq_done_excl, clk_i, rst_ni, out_valid_q |-> !(drq_q && done_q), "drq with done")

  // The output register is empty in the cycle after reset is seen.
  `FDC_ASSERT_ALWAYS(a_reset_empty, clk_i, !rst_ni |=> !out_valid_q, "valid after reset")

endmodule

@@ rtl/core/fdc_apb_regs.sv @@
`timescale 1ns / 1ps

module fdc_apb_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [fdc_pkg::APB_AW-1:0]   paddr,
  input  logic [fdc_pkg::APB_DW-1:0]   pwdata,
  output logic [fdc_pkg::APB_DW-1:0]   prdata,
  output logic                         pready,
  output fdc_pkg::fdc_cfg_t            cfg_o
);

  fdc_pkg::fdc_cfg_t cfg_q, cfg_d;
  logic              wr_en;
  logic              reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[2];

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        fdc_pkg::CFG_COMMAND_DELAY: cfg_d.command_delay = pwdata[fdc_pkg::WAIT_W-1:0];
        fdc_pkg::CFG_STEP_DELAY:    cfg_d.step_delay    = pwdata[fdc_pkg::WAIT_W-1:0];
        default:                    cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.command_delay <= fdc_pkg::COMMAND_DELAY_RST;
      cfg_q.step_delay    <= fdc_pkg::STEP_DELAY_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    case (reg_idx)
      fdc_pkg::CFG_COMMAND_DELAY:
        prdata = fdc_pkg::APB_DW'(cfg_q.command_delay);
      fdc_pkg::CFG_STEP_DELAY:
        prdata = fdc_pkg::APB_DW'(cfg_q.step_delay);
      default:
        prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

@@ rtl/core/fdc_engine.sv @@
`timescale 1ns / 1ps

module fdc_engine #(
  parameter int LONG_SECTOR_BYTES  = fdc_pkg::LONG_SECTOR_BYTES_DEF,
  parameter int SHORT_SECTOR_BYTES = fdc_pkg::SHORT_SECTOR_BYTES_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        accept_i,
  input  logic [1:0]                  kind_i,
  input  logic [1:0]                  reg_select_i,
  input  logic [fdc_pkg::BYTE_W-1:0]  write_data_i,
  input  logic [fdc_pkg::BYTE_W-1:0]  disk_byte_i,
  input  fdc_pkg::fdc_cfg_t           cfg_i,
  output fdc_pkg::fdc_step_t          step_o
);

  localparam logic [fdc_pkg::IDX_W-1:0] LongLimit  = fdc_pkg::IDX_W'(LONG_SECTOR_BYTES);
  localparam logic [fdc_pkg::IDX_W-1:0] ShortLimit = fdc_pkg::IDX_W'(SHORT_SECTOR_BYTES);

  logic [fdc_pkg::STAT_W-1:0] status_q, status_d;
  logic [fdc_pkg::BYTE_W-1:0] cmd_q, cmd_d;
  logic [fdc_pkg::BYTE_W-1:0] track_q, track_d;
  logic [fdc_pkg::BYTE_W-1:0] sector_q, sector_d;
  logic [fdc_pkg::BYTE_W-1:0] data_q, data_d;
  logic [fdc_pkg::IDX_W-1:0]  idx_q, idx_d;
  logic [fdc_pkg::WAIT_W-1:0] wait_q, wait_d;

  logic [fdc_pkg::BYTE_W-1:0] rd_data;
  logic                       drq;
  logic                       done;
  logic [3:0]                 wr_op;
  logic [fdc_pkg::IDX_W-1:0]  limit;

  assign wr_op = write_data_i[7:4];
  assign limit = (sector_q == fdc_pkg::SHORT_SECTOR_ID) ? ShortLimit : LongLimit;

  always_comb begin
    status_d = status_q;
    cmd_d    = cmd_q;
    track_d  = track_q;
    sector_d = sector_q;
    data_d   = data_q;
    idx_d    = idx_q;
    wait_d   = wait_q;
    rd_data  = '0;
    drq      = 1'b0;
    done     = 1'b0;

    case (kind_i)
      fdc_pkg::KIND_READ: begin
        case (reg_select_i)
          fdc_pkg::SEL_STATUS: rd_data = fdc_pkg::BYTE_W'(status_q);
          fdc_pkg::SEL_TRACK:  rd_data = track_q;
          fdc_pkg::SEL_SECTOR: rd_data = sector_q;
          default: begin
            status_d[fdc_pkg::ST_DRQ] = 1'b0;
            rd_data = data_q;
          end
        endcase
      end

      fdc_pkg::KIND_WRITE: begin
        case (reg_select_i)
          fdc_pkg::SEL_STATUS: begin
            if (wr_op == fdc_pkg::OP_FORCE_INT) begin
              status_d[fdc_pkg::ST_BUSY] = 1'b0;
            end else if (!status_q[fdc_pkg::ST_BUSY]) begin
              cmd_d = write_data_i;
              case (wr_op)
                fdc_pkg::OP_RESTORE, fdc_pkg::OP_STEP_OUT: begin
                  wait_d   = cfg_i.command_delay;
                  status_d = fdc_pkg::STAT_W'(1) << fdc_pkg::ST_BUSY;
                end
                fdc_pkg::OP_SEEK: begin
                  wait_d  = cfg_i.command_delay;
                  status_d[fdc_pkg::ST_BUSY] = 1'b1;
                  track_d = data_q;
                end
                fdc_pkg::OP_STEP, fdc_pkg::OP_STEP_U, fdc_pkg::OP_STEP_IN: begin
                  // Command byte is loaded; nothing else moves.
                end
                fdc_pkg::OP_STEP_IN_U: begin
                  wait_d  = cfg_i.command_delay;
                  track_d = track_q + 8'd1;
                  status_d[fdc_pkg::ST_BUSY] = 1'b1;
                end
                fdc_pkg::OP_STEP_OUT_U: begin
                  wait_d  = cfg_i.command_delay;
                  track_d = track_q - 8'd1;
                  status_d[fdc_pkg::ST_BUSY] = 1'b1;
                end
                fdc_pkg::OP_READ_SECTOR: begin
                  wait_d   = cfg_i.command_delay;
                  idx_d    = '0;
                  status_d = fdc_pkg::STAT_W'(1) << fdc_pkg::ST_BUSY;
                end
                default: begin
                  status_d = '0;
                  wait_d   = '0;
                end
              endcase
            end
          end
          fdc_pkg::SEL_TRACK:  track_d  = write_data_i;
          fdc_pkg::SEL_SECTOR: sector_d = write_data_i;
          default:             data_d   = write_data_i;
        endcase
      end

      fdc_pkg::KIND_TICK: begin
        if (status_q[fdc_pkg::ST_BUSY]) begin
          if (wait_q != '0) begin
            wait_d = wait_q - fdc_pkg::WAIT_W'(1);
          end else begin
            case (cmd_q[7:4])
              fdc_pkg::OP_RESTORE: begin
                track_d  = '0;
                status_d = fdc_pkg::STAT_W'(1) << fdc_pkg::ST_TR00;
                wait_d   = cfg_i.step_delay;
                done     = 1'b1;
              end
              fdc_pkg::OP_SEEK: begin
                status_d = (track_q == '0) ? (fdc_pkg::STAT_W'(1) << fdc_pkg::ST_TR00) : '0;
                wait_d   = cfg_i.step_delay;
                done     = 1'b1;
              end
              fdc_pkg::OP_STEP_IN_U, fdc_pkg::OP_STEP_OUT: begin
                status_d[fdc_pkg::ST_BUSY] = 1'b0;
                wait_d = cfg_i.step_delay;
                done   = 1'b1;
              end
              fdc_pkg::OP_READ_SECTOR: begin
                wait_d = cfg_i.step_delay;
                if (idx_q >= limit) begin
                  // Past the last byte: end the command without a byte.
                  status_d[fdc_pkg::ST_BUSY] = 1'b0;
                  done = 1'b1;
                end else begin
                  data_d = disk_byte_i;
                  status_d[fdc_pkg::ST_DRQ] = 1'b1;
                  idx_d = idx_q + fdc_pkg::IDX_W'(1);
                  drq   = 1'b1;
                end
              end
              default: begin
                status_d = '0;
              end
            endcase
          end
        end
      end

      default: begin
        // Unused kind: no state change.
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q <= '0;
      cmd_q    <= '0;
      track_q  <= '0;
      sector_q <= '0;
      data_q   <= '0;
      idx_q    <= '0;
      wait_q   <= '0;
    end else if (accept_i) begin
      status_q <= status_d;
      cmd_q    <= cmd_d;
      track_q  <= track_d;
      sector_q <= sector_d;
      data_q   <= data_d;
      idx_q    <= idx_d;
      wait_q   <= wait_d;
    end
  end

  always_comb begin
    step_o.read_data    = rd_data;
    step_o.data_request = drq;
    step_o.command_done = done;
    step_o.busy         = status_d[fdc_pkg::ST_BUSY];
    step_o.track        = track_d;
    step_o.sector       = sector_d;
    step_o.byte_index   = idx_d;
  end

endmodule
